>>> hdl/nlag_pkg.sv
// shared types and constants for the nested loop address generator
// no dependencies
`default_nettype none
package nlag_pkg;

  localparam int unsigned RegW     = 16;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgLevels = 4;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_MUL  = 3'd1,
    OP_ADD  = 3'd2,
    OP_AND  = 3'd3,
    OP_MOD  = 3'd4,
    OP_ASR  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    MODE_ADDR  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TRIP0  = 4'd0,
    CFG_TRIP1  = 4'd1,
    CFG_TRIP2  = 4'd2,
    CFG_TRIP3  = 4'd3,
    CFG_SCALE0 = 4'd4,
    CFG_SCALE1 = 4'd5,
    CFG_SCALE2 = 4'd6,
    CFG_SCALE3 = 4'd7
  } cfg_e;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_LDIV  = 9'b000000010,
    ST_LWAIT = 9'b000000100,
    ST_TERM  = 9'b000001000,
    ST_RD    = 9'b000010000,
    ST_OP    = 9'b000100000,
    ST_MWAIT = 9'b001000000,
    ST_SCL   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  // first member is the most significant: mode ends up in the lowest bits
  typedef struct packed {
    logic [15:0] op_factor;
    logic [2:0]  op_code;
    logic [1:0]  slot_sel;
    logic        term_sel;
    logic [1:0]  level_sel;
    logic [23:0] iteration;
    logic [1:0]  mode;
  } in_item_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [15:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> hdl/nlag_div.sv
// iterative unsigned divider, 32-bit dividend by 16-bit divisor, one bit a cycle
// depends on nlag_pkg
`default_nettype none
module nlag_div import nlag_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic [15:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [15:0] dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [16:0] sh;
  logic [16:0] diff;
  logic        ge;

  always_comb begin
    sh   = {rem_q, quo_q[31]};
    diff = sh - {1'b0, dvs_q};
    ge   = sh >= {1'b0, dvs_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[15:0] : sh[15:0];
      quo_d = {quo_q[30:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

>>> hdl/nested_loop_address_generator_core.sv
// nested loop address generator: op table memory, level sequencer and chain walk
// depends on nlag_pkg and nlag_div
// writes, clears and no-op items go straight to the result register; an address request
// runs a divider step per level and a walk of each term at every level, longer for each
// written chain and each modulo op, set by the shared one-bit-per-cycle divider and the op
// table, one slot per read; tready rises in the cycle after the result register loads
// reset sets config registers to 1, clears table valid bits and control; no clearing pass
`default_nettype none
module nested_loop_address_generator_core import nlag_pkg::*; #(
  parameter int unsigned LEVELS = 4,
  parameter int unsigned TERMS  = 2,
  parameter int unsigned OPS    = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [RegW-1:0]      cfg_wdata_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // mode, iteration, level_sel, term_sel, slot_sel, op_code, op_factor
  input  wire logic [InDataW-1:0]   s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // address, div_error
  output logic [OutDataW-1:0]       m_axis_tdata
);

  localparam int unsigned Depth = LEVELS * TERMS * OPS;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned TW = (TERMS > 1) ? $clog2(TERMS) : 1;
  localparam int unsigned KW = (OPS > 1) ? $clog2(OPS) : 1;

  logic [RegW-1:0] trip_q [CfgLevels];
  logic [RegW-1:0] scale_q [CfgLevels];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CfgLevels; i++) begin
        trip_q[i]  <= 16'd1;
        scale_q[i] <= 16'd1;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TRIP0:  trip_q[0]  <= cfg_wdata_i;
        CFG_TRIP1:  trip_q[1]  <= cfg_wdata_i;
        CFG_TRIP2:  trip_q[2]  <= cfg_wdata_i;
        CFG_TRIP3:  trip_q[3]  <= cfg_wdata_i;
        CFG_SCALE0: scale_q[0] <= cfg_wdata_i;
        CFG_SCALE1: scale_q[1] <= cfg_wdata_i;
        CFG_SCALE2: scale_q[2] <= cfg_wdata_i;
        CFG_SCALE3: scale_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  in_item_t in_item;
  assign in_item = in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);

  state_e state_q, state_d;
  logic [LW-1:0] lv_q, lv_d;
  logic [TW-1:0] t_q, t_d;
  logic [KW-1:0] k_q, k_d;
  logic [31:0]   q_q, q_d;
  logic [15:0]   idx_q, idx_d;
  logic [31:0]   v_q, v_d;
  logic [31:0]   acc_q, acc_d;
  logic          err_q, err_d;
  logic          neg_q, neg_d;
  logic [Depth-1:0] vld_q, vld_d;
  logic          out_vld_q, out_vld_d;
  logic [31:0]   out_addr_q, out_addr_d;
  logic          out_err_q, out_err_d;

  logic [18:0]   mem [Depth];
  logic [18:0]   rd_q;
  logic          rd_vld_q;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [AW-1:0] chain_base;
  logic          chain_vld;
  logic [15:0]   trip_cur, scale_cur;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  logic [2:0]    op_code;
  logic [31:0]   fact;
  logic [31:0]   v_abs;
  logic [15:0]   f_abs;
  logic [4:0]    shamt;
  logic          wr_ok;

  nlag_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    trip_cur  = 16'd1;
    scale_cur = 16'd1;
    for (int i = 0; i < CfgLevels; i++) begin
      if (int'(lv_q) == i) begin
        trip_cur  = trip_q[i];
        scale_cur = scale_q[i];
      end
    end
  end

  assign chain_base = AW'((int'(lv_q) * TERMS + int'(t_q)) * OPS);
  assign raddr = AW'(int'(chain_base) + int'(k_q));
  assign waddr = AW'((int'(in_item.level_sel) * TERMS + int'(in_item.term_sel)) * OPS
                     + int'(in_item.slot_sel));
  assign wr_ok = (int'(in_item.level_sel) < LEVELS) && (int'(in_item.term_sel) < TERMS)
                 && (int'(in_item.slot_sel) < OPS);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign we = s_axis_tvalid && s_axis_tready && (in_item.mode == MODE_WRITE) && wr_ok;

  always_comb begin
    chain_vld = 1'b0;
    for (int k = 0; k < OPS; k++) begin
      chain_vld = chain_vld | vld_q[AW'(int'(chain_base) + k)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= {in_item.op_code, in_item.op_factor};
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[raddr];
    end
  end

  assign op_code = rd_vld_q ? rd_q[18:16] : OP_NONE;
  assign fact    = rd_vld_q ? {{16{rd_q[15]}}, rd_q[15:0]} : 32'd0;
  assign v_abs   = v_q[31] ? (32'd0 - v_q) : v_q;
  assign f_abs   = fact[31] ? (16'd0 - fact[15:0]) : fact[15:0];

  always_comb begin
    if (fact[31]) begin
      shamt = 5'd0;
    end else if (fact[15:5] != '0) begin
      shamt = 5'd31;
    end else begin
      shamt = fact[4:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    lv_d       = lv_q;
    t_d        = t_q;
    k_d        = k_q;
    q_d        = q_q;
    idx_d      = idx_q;
    v_d        = v_q;
    acc_d      = acc_q;
    err_d      = err_q;
    neg_d      = neg_q;
    vld_d      = vld_q;
    out_vld_d  = out_vld_q;
    out_addr_d = out_addr_q;
    out_err_d  = out_err_q;
    div_req.start    = 1'b0;
    div_req.dividend = q_q;
    div_req.divisor  = trip_cur;

    if (m_axis_tvalid && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          acc_d = '0;
          err_d = 1'b0;
          q_d   = {8'd0, in_item.iteration};
          lv_d  = LW'(LEVELS - 1);
          case (in_item.mode)
            MODE_ADDR:  state_d = ST_LDIV;
            MODE_WRITE: begin
              if (wr_ok) begin
                vld_d[waddr] = 1'b1;
              end
              state_d = ST_DONE;
            end
            MODE_CLEAR: begin
              vld_d   = '0;
              state_d = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_LDIV: begin
        if (trip_cur == 16'd0) begin
          err_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          div_req.start = 1'b1;
          state_d = ST_LWAIT;
        end
      end
      ST_LWAIT: begin
        if (div_rsp.done) begin
          q_d     = div_rsp.quot;
          idx_d   = div_rsp.rem;
          t_d     = '0;
          state_d = ST_TERM;
        end
      end
      ST_TERM: begin
        k_d = '0;
        v_d = {16'd0, idx_q};
        if (chain_vld) begin
          state_d = ST_RD;
        end else begin
          state_d = ST_SCL;
        end
      end
      ST_RD: begin
        state_d = ST_OP;
      end
      ST_OP: begin
        state_d = ST_RD;
        case (op_code)
          OP_MUL: v_d = v_q * fact;
          OP_ADD: v_d = v_q + fact;
          OP_AND: v_d = v_q & fact;
          OP_ASR: v_d = $unsigned($signed(v_q) >>> shamt);
          OP_MOD: begin
            if (fact == 32'd0) begin
              err_d = 1'b1;
              v_d   = '0;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = v_abs;
              div_req.divisor  = f_abs;
              neg_d   = v_q[31];
              state_d = ST_MWAIT;
            end
          end
          default: ;
        endcase
        if (state_d != ST_MWAIT) begin
          if (int'(k_q) == OPS - 1) begin
            state_d = ST_SCL;
          end else begin
            k_d = k_q + KW'(1);
          end
        end
      end
      ST_MWAIT: begin
        if (div_rsp.done) begin
          v_d = neg_q ? (32'd0 - {16'd0, div_rsp.rem}) : {16'd0, div_rsp.rem};
          if (int'(k_q) == OPS - 1) begin
            state_d = ST_SCL;
          end else begin
            k_d = k_q + KW'(1);
            state_d = ST_RD;
          end
        end
      end
      ST_SCL: begin
        if (chain_vld) begin
          acc_d = acc_q + 32'(v_q * {16'd0, scale_cur});
        end
        if (int'(t_q) == TERMS - 1) begin
          if (lv_q == '0) begin
            state_d = ST_DONE;
          end else begin
            lv_d    = lv_q - LW'(1);
            state_d = ST_LDIV;
          end
        end else begin
          t_d     = t_q + TW'(1);
          state_d = ST_TERM;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_addr_d = err_q ? 32'd0 : acc_q;
          out_err_d  = err_q;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
      lv_q      <= '0;
      t_q       <= '0;
      k_q       <= '0;
      err_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
      lv_q      <= lv_d;
      t_q       <= t_d;
      k_q       <= k_d;
      err_q     <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q        <= q_d;
    idx_q      <= idx_d;
    v_q        <= v_d;
    acc_q      <= acc_d;
    neg_q      <= neg_d;
    out_addr_q <= out_addr_d;
    out_err_q  <= out_err_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_err_q, out_addr_q};

endmodule
`default_nettype wire

>>> verif/testbench.sv
// self-checking testbench for nested_loop_address_generator_core: streams table writes,
// clears and address requests, predicts each result in a local model and checks every transaction
// depends on nlag_pkg and the core rtl
`default_nettype none
module testbench;
  import nlag_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [RegW-1:0]     cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // mode, iteration, level_sel, term_sel, slot_sel, op_code, op_factor
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // address, div_error
  logic [OutDataW-1:0] m_axis_tdata;

  nested_loop_address_generator_core u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  typedef struct packed {
    logic [31:0] address;
    logic        div_error;
  } addr_rsp_t;

  // local copy of table and registers
  logic [2:0]  tbl_code [4][2][4];
  logic [31:0] tbl_fact [4][2][4];
  bit          chain_on [4][2];
  logic [15:0] trip_reg [4];
  logic [15:0] scale_reg [4];

  addr_rsp_t pending_rsp[$];
  int        errors;
  int        src_idle_pct;
  int        snk_idle_pct;
  bit        hold_off;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic logic [31:0] run_slot(input logic [31:0] v, input logic [2:0] code,
                                           input logic [31:0] f, inout bit err);
    int sh;
    case (code)
      OP_MUL: return v * f;
      OP_ADD: return v + f;
      OP_AND: return v & f;
      OP_MOD: begin
        if (f == 32'd0) begin
          err = 1'b1;
          return 32'd0;
        end
        if (f == 32'hFFFF_FFFF) return 32'd0;
        return $signed(v) % $signed(f);
      end
      OP_ASR: begin
        sh = $signed(f);
        if (sh < 0) sh = 0;
        if (sh > 31) sh = 31;
        return $signed(v) >>> sh;
      end
      default: return v;
    endcase
  endfunction

  function automatic addr_rsp_t predict_address(input logic [23:0] iter);
    addr_rsp_t r;
    longint unsigned dvs;
    logic [31:0] idx, v, acc;
    bit err;
    dvs = 1;
    acc = '0;
    err = 1'b0;
    for (int lv = 3; lv >= 0 && !err; lv--) begin
      if (trip_reg[lv] == 0) begin
        err = 1'b1;
        break;
      end
      idx = 32'((longint'(iter) / dvs) % trip_reg[lv]);
      for (int t = 0; t < 2; t++) begin
        if (!chain_on[lv][t]) continue;
        v = idx;
        for (int k = 0; k < 4; k++) v = run_slot(v, tbl_code[lv][t][k], tbl_fact[lv][t][k], err);
        acc = acc + v * {16'd0, scale_reg[lv]};
      end
      dvs = dvs * trip_reg[lv];
      if (dvs > 64'h1_0000_0000) dvs = 64'h1_0000_0000;
    end
    r.address = err ? 32'd0 : acc;
    r.div_error = err;
    return r;
  endfunction

  task automatic clear_model();
    for (int l = 0; l < 4; l++)
      for (int t = 0; t < 2; t++) begin
        chain_on[l][t] = 1'b0;
        for (int k = 0; k < 4; k++) begin
          tbl_code[l][t][k] = OP_NONE;
          tbl_fact[l][t][k] = '0;
        end
      end
  endtask

  task automatic write_reg(input cfg_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx <= CFG_TRIP3) trip_reg[idx] = val;
    else scale_reg[idx - CFG_SCALE0] = val;
  endtask

  task automatic send_item(input mode_e mode, input logic [23:0] iter, input logic [1:0] lv,
                           input logic ts, input logic [1:0] sl, input op_e code,
                           input logic [15:0] fact);
    addr_rsp_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata = InDataW'({$urandom, $urandom});
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {6'd0, fact, code, sl, ts, lv, iter, mode};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = '0;
    case (mode)
      MODE_ADDR: r = predict_address(iter);
      MODE_WRITE: begin
        tbl_code[lv][ts][sl] = code;
        tbl_fact[lv][ts][sl] = {{16{fact[15]}}, fact};
        chain_on[lv][ts] = 1'b1;
      end
      MODE_CLEAR: clear_model();
      default: ;
    endcase
    pending_rsp.insert(pending_rsp.size(), r);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_rsp.size() != 0 && guard < 2000000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (40) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_factor();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(8)) - 4);
      2: return 16'($urandom_range(40));
      default: return 16'($urandom_range(15));
    endcase
  endfunction

  task automatic send_random();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55)
      send_item(MODE_ADDR, $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(2000)),
                0, 0, 0, OP_NONE, 0);
    else if (pick < 95)
      send_item(MODE_WRITE, 24'($urandom), 2'($urandom), 1'($urandom), 2'($urandom),
                op_e'($urandom_range(5)), rand_factor());
    else
      send_item(MODE_CLEAR, 24'($urandom), 2'($urandom), 1'($urandom), 2'($urandom),
                op_e'($urandom_range(5)), 16'($urandom));
  endtask

  task automatic test_directed();
    send_item(MODE_ADDR, 24'hFFFFFF, 0, 0, 0, OP_NONE, 0);
    drain();
    write_reg(CFG_TRIP3, 16'd7);
    write_reg(CFG_TRIP2, 16'd5);
    write_reg(CFG_TRIP1, 16'd3);
    write_reg(CFG_TRIP0, 16'd65535);
    write_reg(CFG_SCALE0, 16'd65535);
    write_reg(CFG_SCALE1, 16'd0);
    write_reg(CFG_SCALE2, 16'd4);
    write_reg(CFG_SCALE3, 16'd1);
    send_item(MODE_ADDR, 24'd0, 0, 0, 0, OP_NONE, 0);
    send_item(MODE_WRITE, 0, 2'd3, 1'b0, 2'd0, OP_MUL, 16'h7FFF);
    send_item(MODE_WRITE, 0, 2'd3, 1'b0, 2'd1, OP_ADD, 16'h8000);
    send_item(MODE_WRITE, 0, 2'd3, 1'b0, 2'd2, OP_ASR, 16'hFFFF);
    send_item(MODE_WRITE, 0, 2'd3, 1'b0, 2'd3, OP_ASR, 16'd40);
    send_item(MODE_WRITE, 0, 2'd2, 1'b1, 2'd0, OP_AND, 16'h0003);
    send_item(MODE_WRITE, 0, 2'd2, 1'b1, 2'd1, OP_MOD, 16'hFFFF);
    send_item(MODE_WRITE, 0, 2'd0, 1'b1, 2'd3, OP_MOD, 16'hFFFD);
    send_item(MODE_WRITE, 0, 2'd1, 1'b0, 2'd0, OP_NONE, 16'h1234);
    send_item(MODE_ADDR, 24'hFFFFFF, 0, 0, 0, OP_NONE, 0);
    send_item(MODE_ADDR, 24'd12345, 0, 0, 0, OP_NONE, 0);
    send_item(MODE_WRITE, 0, 2'd0, 1'b0, 2'd2, OP_MOD, 16'h0000);
    send_item(MODE_ADDR, 24'd77, 0, 0, 0, OP_NONE, 0);
    send_item(MODE_CLEAR, 0, 0, 0, 0, OP_NONE, 0);
    send_item(MODE_ADDR, 24'hABCDEF, 0, 0, 0, OP_NONE, 0);
    send_item(MODE_WRITE, 0, 2'd1, 1'b1, 2'd2, OP_ADD, 16'hFFFE);
    send_item(MODE_ADDR, 24'hFFFFFF, 0, 0, 0, OP_NONE, 0);
    drain();
  endtask

  task automatic test_random_phase(input int n, input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int c = 0; c < 8; c++)
      if (c < 4) write_reg(cfg_e'(c), 16'($urandom_range(1, c == 0 ? 65535 : 40)));
      else write_reg(cfg_e'(c), $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(9)));
    repeat (n) send_random();
    drain();
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        @(negedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    repeat (12) send_random();
    drain();
  endtask

  always @(negedge clk_i)
    m_axis_tready = !hold_off && ($urandom_range(99) >= snk_idle_pct);

  always @(posedge clk_i) begin
    addr_rsp_t want;
    addr_rsp_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.address = m_axis_tdata[31:0];
      got.div_error = m_axis_tdata[32];
      if (pending_rsp.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = pending_rsp.pop_front();
        if (got.address !== want.address)
          report_mismatch($sformatf("address %h, want %h", got.address, want.address));
        if (got.div_error !== want.div_error)
          report_mismatch($sformatf("div_error %b, want %b", got.div_error, want.div_error));
      end
    end
  end

  initial begin
    errors = 0;
    hold_off = 1'b0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    for (int l = 0; l < 4; l++) begin
      trip_reg[l] = 16'd1;
      scale_reg[l] = 16'd1;
    end
    clear_model();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_phase(300, 30, 46);
    test_random_phase(300, 46, 30);
    test_backpressure();
    test_random_phase(300, 0, 0);
    if (pending_rsp.size() != 0) report_mismatch("results still outstanding at end");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
hdl/nlag_pkg.sv
hdl/nlag_div.sv
hdl/nested_loop_address_generator_core.sv
verif/testbench.sv
